[rtl/core/bm25ds_pkg.sv]
package bm25ds_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 24;
    localparam int SCORE_W        = 48;
    localparam int MUL_W          = 64;
    localparam int MB_W           = 32;
    localparam int DIV_W          = 64;
    localparam int DVS_W          = 48;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 32;

    typedef struct packed {
        logic [23:0] collection_count;
        logic [15:0] doc_term_count;
        logic [23:0] doc_len;
        logic        last_term;
    } t_in;

    typedef struct packed {
        logic signed [SCORE_W-1:0] total_score;
        logic                      length_error;
    } t_out;

    typedef struct packed {
        logic [15:0] k_one;
        logic [16:0] length_weight;
        logic [31:0] mean_doc_length;
        logic [23:0] vocab_size;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K_ONE           = 8'd0,
        CFG_LENGTH_WEIGHT   = 8'd1,
        CFG_MEAN_DOC_LENGTH = 8'd2,
        CFG_VOCAB_SIZE      = 8'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SET_N,
        CMD_SET_D,
        CMD_NORM,
        CMD_LOG_MUL,
        CMD_LOG_N,
        CMD_LOG_D,
        CMD_IDF_MUL,
        CMD_IDF,
        CMD_BAV_MUL,
        CMD_DIV_K,
        CMD_KVAL,
        CMD_KK_MUL,
        CMD_DEN,
        CMD_NUM_MUL,
        CMD_DIV_TF,
        CMD_TF,
        CMD_W_MUL,
        CMD_ACC,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic dl_zero;
        logic norm_done;
        logic mul_done;
        logic div_done;
        logic last;
        logic out_free;
    } t_stat;

    // log2(1 + i/16), Q.16
    function automatic logic [16:0] log_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/bm25_document_score_top.sv]
// From request to score, the time is set by two 64-step restoring divisions, the
// bit-serial multiplier (one bit per cycle) and up to 24 normalization shifts per
// log argument; at zero document length all of these are skipped.
// One term request at a time: the next is taken only once the previous term is done.
// A finished score waits in the output register while the next term is taken.
// Reset: synchronous, active low; clears control and score state, loads the default config.
module bm25_document_score_top
    import bm25ds_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k_one           <= 16'd4915;
            r_cfg.length_weight   <= 17'd49152;
            r_cfg.mean_doc_length <= 32'd256;
            r_cfg.vocab_size      <= 24'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_K_ONE:           r_cfg.k_one           <= i_cfg_data[15:0];
                CFG_LENGTH_WEIGHT:   r_cfg.length_weight   <= i_cfg_data[16:0];
                CFG_MEAN_DOC_LENGTH: r_cfg.mean_doc_length <= i_cfg_data;
                CFG_VOCAB_SIZE:      r_cfg.vocab_size      <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    bm25ds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bm25ds_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_stat  (stat)
    );

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready high right after request");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("reset did not clear control state");

    a_score_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("score appeared without a request in work");

endmodule

[rtl/core/bm25ds_ctrl.sv]
module bm25ds_ctrl
    import bm25ds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_SET_N, ST_NORM_N, ST_LMUL_N, ST_LWAIT_N, ST_LOG_N,
        ST_SET_D, ST_NORM_D, ST_LMUL_D, ST_LWAIT_D, ST_LOG_D,
        ST_IDF_MUL, ST_IDF_WAIT, ST_IDF, ST_BAV_MUL, ST_BAV_WAIT,
        ST_DIV_K, ST_DIV_K_WAIT, ST_KVAL, ST_KK_MUL, ST_KK_WAIT, ST_DEN,
        ST_NUM_MUL, ST_NUM_WAIT, ST_DIV_TF, ST_DIV_TF_WAIT, ST_TF,
        ST_W_MUL, ST_W_WAIT, ST_ACC, ST_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_SET_N;
                end
            end
            ST_SET_N: begin
                o_cmd   = CMD_SET_N;
                n_state = i_stat.dl_zero ? ST_ACC : ST_NORM_N;
            end
            ST_NORM_N: begin
                o_cmd = CMD_NORM;
                if (i_stat.norm_done) n_state = ST_LMUL_N;
            end
            ST_LMUL_N: begin
                o_cmd   = CMD_LOG_MUL;
                n_state = ST_LWAIT_N;
            end
            ST_LWAIT_N: if (i_stat.mul_done) n_state = ST_LOG_N;
            ST_LOG_N: begin
                o_cmd   = CMD_LOG_N;
                n_state = ST_SET_D;
            end
            ST_SET_D: begin
                o_cmd   = CMD_SET_D;
                n_state = ST_NORM_D;
            end
            ST_NORM_D: begin
                o_cmd = CMD_NORM;
                if (i_stat.norm_done) n_state = ST_LMUL_D;
            end
            ST_LMUL_D: begin
                o_cmd   = CMD_LOG_MUL;
                n_state = ST_LWAIT_D;
            end
            ST_LWAIT_D: if (i_stat.mul_done) n_state = ST_LOG_D;
            ST_LOG_D: begin
                o_cmd   = CMD_LOG_D;
                n_state = ST_IDF_MUL;
            end
            ST_IDF_MUL: begin
                o_cmd   = CMD_IDF_MUL;
                n_state = ST_IDF_WAIT;
            end
            ST_IDF_WAIT: if (i_stat.mul_done) n_state = ST_IDF;
            ST_IDF: begin
                o_cmd   = CMD_IDF;
                n_state = ST_BAV_MUL;
            end
            ST_BAV_MUL: begin
                o_cmd   = CMD_BAV_MUL;
                n_state = ST_BAV_WAIT;
            end
            ST_BAV_WAIT: if (i_stat.mul_done) n_state = ST_DIV_K;
            ST_DIV_K: begin
                o_cmd   = CMD_DIV_K;
                n_state = ST_DIV_K_WAIT;
            end
            ST_DIV_K_WAIT: if (i_stat.div_done) n_state = ST_KVAL;
            ST_KVAL: begin
                o_cmd   = CMD_KVAL;
                n_state = ST_KK_MUL;
            end
            ST_KK_MUL: begin
                o_cmd   = CMD_KK_MUL;
                n_state = ST_KK_WAIT;
            end
            ST_KK_WAIT: if (i_stat.mul_done) n_state = ST_DEN;
            ST_DEN: begin
                o_cmd   = CMD_DEN;
                n_state = ST_NUM_MUL;
            end
            ST_NUM_MUL: begin
                o_cmd   = CMD_NUM_MUL;
                n_state = ST_NUM_WAIT;
            end
            ST_NUM_WAIT: if (i_stat.mul_done) n_state = ST_DIV_TF;
            ST_DIV_TF: begin
                o_cmd   = CMD_DIV_TF;
                n_state = ST_DIV_TF_WAIT;
            end
            ST_DIV_TF_WAIT: if (i_stat.div_done) n_state = ST_TF;
            ST_TF: begin
                o_cmd   = CMD_TF;
                n_state = ST_W_MUL;
            end
            ST_W_MUL: begin
                o_cmd   = CMD_W_MUL;
                n_state = ST_W_WAIT;
            end
            ST_W_WAIT: if (i_stat.mul_done) n_state = ST_ACC;
            ST_ACC: begin
                o_cmd   = CMD_ACC;
                n_state = i_stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/bm25ds_datapath.sv]
module bm25ds_datapath
    import bm25ds_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_data,
    input  t_cfg  i_cfg,
    input  logic  i_ready,
    output logic  o_valid,
    output t_out  o_data,
    output t_stat o_stat
);

    localparam int CW    = (COUNT_BITS < 24) ? COUNT_BITS : 24;
    localparam int W     = CW + 1;
    localparam int LR    = W - 5;
    localparam int E_W   = $clog2(W);
    localparam int LOG_W = 22;
    localparam int IDF_W = 24;
    localparam int TF_W  = 32;

    logic [CW-1:0]     r_c;
    logic [15:0]       r_f;
    logic [CW-1:0]     r_dl;
    logic              r_last;
    logic              r_dlz;
    logic [W-1:0]      r_x;
    logic [E_W-1:0]    r_e;
    logic [LOG_W-1:0]  r_logn, r_logd;
    logic              r_neg;
    logic [IDF_W-1:0]  r_idf;
    logic [DVS_W-1:0]  r_kval;
    logic [DVS_W-1:0]  r_den;
    logic [TF_W-1:0]   r_tf;
    logic signed [SCORE_W-1:0] r_sum;
    logic              r_err;
    logic              r_ov;
    t_out              r_out;

    logic [MUL_W-1:0]  r_ma, r_mp;
    logic [MB_W-1:0]   r_mb;
    logic [DIV_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem, r_dd;
    logic [6:0]        r_dcnt;

    logic              mul_start;
    logic [MUL_W-1:0]  mul_a;
    logic [MB_W-1:0]   mul_b;
    logic              div_start;
    logic [DIV_W-1:0]  div_n;
    logic [DVS_W-1:0]  div_d;

    logic [CW-1:0]     c_in, v_m;
    logic [3:0]        idx;
    logic [16:0]       t_lo, t_hi;
    logic [16:0]       b_cl;
    logic [LOG_W-1:0]  diff;
    logic              neg_now;
    logic [DVS_W:0]    div_sh;
    logic              div_ge;
    logic [MUL_W-1:0]  mag;
    logic signed [SCORE_W+1:0] acc;
    logic signed [SCORE_W+1:0] sat_max, sat_min;

    assign c_in    = i_data.collection_count[CW-1:0];
    assign v_m     = i_cfg.vocab_size[CW-1:0];
    assign idx     = r_x[W-2 -: 4];
    assign t_lo    = log_tab({1'b0, idx});
    assign t_hi    = log_tab({1'b0, idx} + 5'd1);
    assign b_cl    = i_cfg.length_weight[16] ? 17'h10000 : i_cfg.length_weight;
    assign neg_now = r_logn < r_logd;
    assign diff    = neg_now ? (r_logd - r_logn) : (r_logn - r_logd);
    assign div_sh  = {r_rem, r_q[DIV_W-1]};
    assign div_ge  = div_sh >= {1'b0, r_dd};
    assign mag     = (r_mp + (MUL_W'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    assign sat_max = {2'b00, 1'b0, {(SCORE_W-1){1'b1}}};
    assign sat_min = {2'b11, 1'b1, {(SCORE_W-1){1'b0}}};

    always_comb begin
        acc = {{2{r_sum[SCORE_W-1]}}, r_sum};
        if (r_neg) acc = acc - $signed({2'b00, mag[SCORE_W-1:0]});
        else       acc = acc + $signed({2'b00, mag[SCORE_W-1:0]});
    end

    always_comb begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (i_cmd)
            CMD_LOG_MUL: begin
                mul_a = MUL_W'(t_hi - t_lo);
                mul_b = MB_W'(r_x[LR-1:0]);
            end
            CMD_IDF_MUL: begin
                mul_a = MUL_W'(diff);
                mul_b = MB_W'(45426);
            end
            CMD_BAV_MUL: begin
                mul_a = MUL_W'(i_cfg.mean_doc_length);
                mul_b = MB_W'(b_cl);
            end
            CMD_KK_MUL: begin
                mul_a = MUL_W'(r_kval);
                mul_b = MB_W'(i_cfg.k_one);
            end
            CMD_NUM_MUL: begin
                mul_a = MUL_W'({1'b0, i_cfg.k_one} + 17'd4096);
                mul_b = MB_W'(r_f);
            end
            CMD_W_MUL: begin
                mul_a = MUL_W'(r_idf);
                mul_b = r_tf;
            end
            default: mul_start = 1'b0;
        endcase
    end

    always_comb begin
        div_start = 1'b1;
        div_n     = '0;
        div_d     = '0;
        case (i_cmd)
            CMD_DIV_K: begin
                div_n = r_mp;
                div_d = DVS_W'(r_dl);
            end
            CMD_DIV_TF: begin
                div_n = r_mp << 20;
                div_d = r_den;
            end
            default: div_start = 1'b0;
        endcase
    end

    // bit-serial multiplier
    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_ma <= mul_a;
            r_mb <= mul_b;
            r_mp <= '0;
        end else if (r_mb != '0) begin
            if (r_mb[0]) r_mp <= r_mp + r_ma;
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (div_start) begin
            r_dcnt <= 7'(DIV_W);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_q   <= div_n;
            r_rem <= '0;
            r_dd  <= div_d;
        end else if (r_dcnt != '0) begin
            r_q   <= {r_q[DIV_W-2:0], div_ge};
            r_rem <= div_ge ? DVS_W'(div_sh - {1'b0, r_dd}) : div_sh[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_c    <= (c_in > v_m) ? v_m : c_in;
                r_f    <= i_data.doc_term_count;
                r_dl   <= i_data.doc_len[CW-1:0];
                r_last <= i_data.last_term;
                r_dlz  <= (i_data.doc_len[CW-1:0] == '0);
            end
            CMD_SET_N: begin
                r_x <= {v_m - r_c, 1'b1};
                r_e <= E_W'(W - 1);
            end
            CMD_SET_D: begin
                r_x <= {r_c, 1'b1};
                r_e <= E_W'(W - 1);
            end
            CMD_NORM: begin
                if (!r_x[W-1]) begin
                    r_x <= r_x << 1;
                    r_e <= r_e - E_W'(1);
                end
            end
            CMD_LOG_N: r_logn <= LOG_W'({r_e, 16'd0}) + LOG_W'(t_lo) + LOG_W'(r_mp >> LR);
            CMD_LOG_D: r_logd <= LOG_W'({r_e, 16'd0}) + LOG_W'(t_lo) + LOG_W'(r_mp >> LR);
            CMD_IDF_MUL: r_neg <= neg_now;
            CMD_IDF:   r_idf <= IDF_W'((r_mp + MUL_W'(32768)) >> 16);
            CMD_KVAL:  r_kval <= DVS_W'(17'h10000 - b_cl) + DVS_W'(r_q >> 8);
            CMD_DEN:   r_den <= DVS_W'(r_mp >> 12) + DVS_W'({r_f, 16'd0});
            CMD_TF:    r_tf <= (r_den == '0) ? '0 : r_q[TF_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_err <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd == CMD_ACC) begin
                if (r_dlz) begin
                    r_err <= 1'b1;
                end else if (acc > sat_max) begin
                    r_sum <= sat_max[SCORE_W-1:0];
                end else if (acc < sat_min) begin
                    r_sum <= sat_min[SCORE_W-1:0];
                end else begin
                    r_sum <= acc[SCORE_W-1:0];
                end
            end
            if (i_cmd == CMD_EMIT) begin
                r_ov  <= 1'b1;
                r_sum <= '0;
                r_err <= 1'b0;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_EMIT) begin
            r_out.total_score  <= r_sum;
            r_out.length_error <= r_err;
        end
    end

    assign o_valid          = r_ov;
    assign o_data           = r_out;
    assign o_stat.dl_zero   = r_dlz;
    assign o_stat.norm_done = r_x[W-1];
    assign o_stat.mul_done  = (r_mb == '0);
    assign o_stat.div_done  = (r_dcnt == '0);
    assign o_stat.last      = r_last;
    assign o_stat.out_free  = !r_ov || i_ready;

endmodule

[tb/sv/bm25_document_score_top_tb.sv]
module bm25_document_score_top_tb;
    import bm25ds_pkg::*;

    localparam int LIMIT  = 3000000;
    localparam int SETTLE = 400;

    class score_board;
        logic [15:0] k1;
        logic [16:0] bw;
        logic [31:0] avg_len;
        logic [23:0] vocab;
        logic signed [47:0] score_acc;
        bit          err_acc;
        t_out        pending_scores[$];
        int          fails;

        function new();
            k1 = 16'd4915;
            bw = 17'd49152;
            avg_len = 32'd256;
            vocab = 24'd1;
            score_acc = '0;
            err_acc = 1'b0;
            fails = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_K_ONE:           k1 = d[15:0];
                CFG_LENGTH_WEIGHT:   bw = d[16:0];
                CFG_MEAN_DOC_LENGTH: avg_len = d;
                CFG_VOCAB_SIZE:      vocab = d[23:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] log2_q16(logic [63:0] x);
            int unsigned e;
            logic [63:0] m, frac, r, lo, hi;
            int unsigned i;
            e = 0;
            if (x == 0) x = 64'd1;
            while (e < 40 && (x >> (e + 1)) != 0) e++;
            m = x << (40 - e);
            frac = m & ((64'd1 << 40) - 64'd1);
            i = 32'((frac >> 36) & 64'd15);
            r = frac & ((64'd1 << 36) - 64'd1);
            lo = 64'(log_tab(5'(i)));
            hi = 64'(log_tab(5'(i + 1)));
            return (64'(e) << 16) + lo + (((hi - lo) * r) >> 36);
        endfunction

        function void note_request(t_in x);
            logic [63:0] c, f, dl, ln_n, ln_d, diff, idf, b, kval, den, num, tf, mag;
            logic signed [63:0] weight, s;
            bit neg;
            t_out exp_item;
            c = 64'(x.collection_count);
            f = 64'(x.doc_term_count);
            dl = 64'(x.doc_len);
            weight = '0;
            if (c > 64'(vocab)) c = 64'(vocab);
            if (dl == 0) begin
                err_acc = 1'b1;
            end else begin
                ln_n = log2_q16(64'd2 * (64'(vocab) - c) + 64'd1);
                ln_d = log2_q16(64'd2 * c + 64'd1);
                neg = ln_n < ln_d;
                diff = neg ? ln_d - ln_n : ln_n - ln_d;
                idf = (diff * 64'd45426 + 64'd32768) >> 16;
                b = (bw > 17'd65536) ? 64'd65536 : 64'(bw);
                kval = (64'd65536 - b) + (((b * 64'(avg_len)) / dl) >> 8);
                den = ((64'(k1) * kval) >> 12) + (f << 16);
                num = (64'(k1) + 64'd4096) * f;
                tf = (den != 0) ? ((num << 20) / den) : 64'd0;
                mag = (idf * tf + (64'd1 << 15)) >> 16;
                weight = neg ? -$signed(mag) : $signed(mag);
            end
            s = 64'(score_acc) + weight;
            if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
            if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
            score_acc = s[47:0];
            if (x.last_term) begin
                exp_item.total_score = score_acc;
                exp_item.length_error = err_acc;
                pending_scores = {pending_scores, exp_item};
                score_acc = '0;
                err_acc = 1'b0;
            end
        endfunction

        function void check_result(t_out r);
            t_out e;
            if (pending_scores.size() == 0) begin
                $error("unexpected result score=%0d err=%0b", r.total_score, r.length_error);
                fails++;
                return;
            end
            e = pending_scores.pop_front();
            if (r.total_score !== e.total_score) begin
                $error("total_score expected %0d actual %0d", e.total_score, r.total_score);
                fails++;
            end
            if (r.length_error !== e.length_error) begin
                $error("length_error expected %0b actual %0b", e.length_error, r.length_error);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    t_out o_data;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    score_board sb = new();
    int cycles = 0;
    int stall_pct = 0;

    bm25_document_score_top DUT (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        if (cycles % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] k, logic [16:0] b, logic [31:0] a,
                             logic [23:0] v);
        drain();
        write_reg(CFG_K_ONE, 32'(k));
        write_reg(CFG_LENGTH_WEIGHT, 32'(b));
        write_reg(CFG_MEAN_DOC_LENGTH, a);
        write_reg(CFG_VOCAB_SIZE, 32'(v));
    endtask

    int burst_left = 0;

    task automatic send(t_in x);
        int gap;
        i_valid <= 1'b1;
        i_data <= x;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(x);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_in rand_term(logic [23:0] v, bit last);
        t_in x;
        x.collection_count = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                           : 24'($urandom_range(0, v));
        case ($urandom_range(0, 3))
            0: x.doc_term_count = 16'($urandom);
            1: x.doc_term_count = 16'd0;
            default: x.doc_term_count = 16'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 19))
            0: x.doc_len = 24'd0;
            1, 2: x.doc_len = 24'($urandom);
            default: x.doc_len = 24'($urandom_range(1, 5000));
        endcase
        x.last_term = last;
        return x;
    endfunction

    task automatic random_docs(int n_items, logic [23:0] v);
        int n, len;
        n = 0;
        while (n < n_items) begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                send(rand_term(v, j == len - 1 || $urandom_range(0, 30) == 0));
                n++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset config, directed corners
        send('{24'd0, 16'd0, 24'd1, 1'b1});
        send('{24'd1, 16'd1, 24'd1, 1'b0});
        send('{24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1});
        send('{24'd0, 16'd5, 24'd0, 1'b1});

        configure(16'd4915, 17'd49152, 32'd100 << 8, 24'hFFFFFF);
        send('{24'd0, 16'd3, 24'd120, 1'b0});
        send('{24'hFFFFFF, 16'd3, 24'd120, 1'b0});
        send('{24'h7FFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0});
        send('{24'd1, 16'd0, 24'd1, 1'b1});
        send('{24'd10, 16'd2, 24'd0, 1'b0});
        send('{24'd10, 16'd2, 24'd50, 1'b1});
        send('{24'd5000, 16'd1, 24'd1, 1'b1});

        configure(16'hFFFF, 17'h1FFFF, 32'hFFFFFFFF, 24'd1000);
        send('{24'd2000, 16'd1, 24'd1, 1'b1});
        send('{24'd0, 16'd0, 24'd1, 1'b1});
        send('{24'd999, 16'hFFFF, 24'hFFFFFF, 1'b1});
        random_docs(180, 24'd1000);

        configure(16'd0, 17'd0, 32'd256, 24'hFFFFFF);
        send('{24'd3, 16'd0, 24'd7, 1'b1});
        random_docs(180, 24'hFFFFFF);

        configure(16'd4915, 17'd65536, 32'd300 << 8, 24'd50000);
        random_docs(100, 24'd50000);
        drain();
        random_docs(100, 24'd50000);

        configure(16'(($urandom_range(0, 15)) << 12 | $urandom_range(0, 4095)),
                  17'($urandom_range(0, 65536)), 32'($urandom_range(256, 32'hFFFFFFFF)),
                  24'($urandom_range(1, 24'hFFFFFF)));
        random_docs(200, sb.vocab);

        configure(16'd8192, 17'd32768, 32'd1000 << 8, 24'd2);
        random_docs(150, 24'd2);

        configure(16'd6144, 17'd49152, 32'($urandom), 24'($urandom_range(1, 24'hFFFFFF)));
        random_docs(200, sb.vocab);

        drain();
        if (sb.fails == 0 && sb.pending_scores.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
